/* hw/rtl/grmc_pkg.sv */
// Shared widths, register codes and the sine builder for the grid ray marcher.
`default_nettype none
package grmc_pkg;

  localparam int ANGLE_W    = 12;
  localparam int POS_IN_W   = 16;
  localparam int DIST_W     = 18;
  localparam int SHADE_W    = 3;
  localparam int ROWS_W     = 6;
  localparam int STEP_W     = 12;
  localparam int VIEW_W     = 17;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int MAP_REGS   = 4;
  localparam int CELL_W     = 4;
  localparam int MAP_BITS   = 256;
  localparam int ROM_DEPTH  = 1 << ANGLE_W;

  localparam logic [SHADE_W-1:0]  SHADE_FAR         = 3'd6;
  localparam logic [STEP_W-1:0]   STEP_RESET        = 12'd41;
  localparam logic [VIEW_W-1:0]   VIEW_RESET        = 17'd65536;
  localparam logic [HEIGHT_W-1:0] WALL_ABOVE_RESET  = 16'd4915;
  localparam logic [HEIGHT_W-1:0] EYE_HEIGHT_RESET  = 16'd7373;

  // Angles in Q30 radians
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

  // (2k)(2k+1) for the Taylor terms
  localparam logic [63:0] TAYLOR_DEN [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_0_3      = 3'd0,
    REG_MAP_4_7      = 3'd1,
    REG_MAP_8_11     = 3'd2,
    REG_MAP_12_15    = 3'd3,
    REG_STEP_LENGTH  = 3'd4,
    REG_VIEW_DIST    = 3'd5,
    REG_WALL_ABOVE   = 3'd6,
    REG_EYE_HEIGHT   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Rounded sine of a Q30 angle in [0, 2*pi), evaluated while building the table
  function automatic logic signed [63:0] sine_q(input logic [63:0] theta_in,
                                                input int frac_bits);
    logic [63:0] theta;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] sum_pos;
    logic [63:0] sum_neg;
    logic [63:0] mag;
    logic        neg;
    theta = theta_in;
    neg   = 1'b0;
    if (theta > PI_Q30) begin
      neg   = 1'b1;
      theta = TWO_PI_Q30 - theta;
    end
    if (theta > HALF_PI_Q30) begin
      theta = PI_Q30 - theta;
    end
    x       = theta;
    t       = x;
    sum_pos = x;
    sum_neg = '0;
    for (int k = 1; k <= 10; k++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / TAYLOR_DEN[k];
      if ((k & 1) == 1) begin
        sum_neg = sum_neg + t;
      end else begin
        sum_pos = sum_pos + t;
      end
    end
    mag = (sum_pos > sum_neg) ? (sum_pos - sum_neg) : 64'd0;
    mag = (mag + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    if (mag > (64'd1 << frac_bits)) begin
      mag = 64'd1 << frac_bits;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/grmc_trig_rom.sv */
// Cosine and sine table indexed by ray angle, registered read.
`default_nettype none
module grmc_trig_rom #(
  parameter int ANGLE_STEPS = 4096,
  parameter int FRAC_BITS   = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rd_en,
  input  wire logic [grmc_pkg::ANGLE_W-1:0]      addr,
  output logic signed [FRAC_BITS+1:0]            cos_q,
  output logic signed [FRAC_BITS+1:0]            sin_q
);

  localparam int TRIG_W = FRAC_BITS + 2;

  logic signed [TRIG_W-1:0] cos_tab [grmc_pkg::ROM_DEPTH];
  logic signed [TRIG_W-1:0] sin_tab [grmc_pkg::ROM_DEPTH];
  logic signed [TRIG_W-1:0] cos_r;
  logic signed [TRIG_W-1:0] sin_r;

  for (genvar g = 0; g < grmc_pkg::ROM_DEPTH; g++) begin : g_tab
    // angle wraps modulo a full turn
    localparam logic [63:0] AM  = 64'(g % ANGLE_STEPS);
    localparam logic [63:0] TH  = AM * grmc_pkg::TWO_PI_Q30 / ANGLE_STEPS;
    localparam logic [63:0] THC = (TH + grmc_pkg::HALF_PI_Q30) % grmc_pkg::TWO_PI_Q30;
    localparam logic signed [TRIG_W-1:0] SIN_V = TRIG_W'(grmc_pkg::sine_q(TH, FRAC_BITS));
    localparam logic signed [TRIG_W-1:0] COS_V = TRIG_W'(grmc_pkg::sine_q(THC, FRAC_BITS));
    assign sin_tab[g] = SIN_V;
    assign cos_tab[g] = COS_V;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cos_r <= cos_tab[addr];
      sin_r <= sin_tab[addr];
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule
`default_nettype wire

/* hw/rtl/grmc_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module grmc_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 19
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [NUM_W-1:0]    num,
  input  wire logic [DEN_W-1:0]    den,
  output grmc_pkg::div_status_t    status,
  output logic [NUM_W-1:0]         quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, acc_r[NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      acc_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // shift the next numerator bit in, the quotient bit enters at the bottom
      acc_nxt = {acc_r[NUM_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quo         = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a running division");

endmodule
`default_nettype wire

/* hw/rtl/grid_ray_march_column_top.sv */
// Fixed-step grid ray marcher for one screen column: sequencer, march datapath, config.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_eye_x, in_eye_y, in_ray_angle
//   out_     output     out_valid / out_ready out_hit, out_distance, out_shade,
//                                             out_rows_above, out_rows_below
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// The march takes at most ceil(view_distance / step_length) steps per item,
// 1599 at reset values; NUM_W, the divider width, is 23 at default parameters.
// The single-step march loop is followed by the shared serial divider, which gives
// one quotient bit per cycle for shade and the two wall heights.
// Reset is synchronous, active low, and clears control state and the config registers only.
// in_ready is high only between items; a finished result waits in the output
// register, so the next item is taken while it is stalled.
`default_nettype none
module grid_ray_march_column_top #(
  parameter int MAP_SIDE    = 16,
  parameter int HALF_ROWS   = 40,
  parameter int ANGLE_STEPS = 4096,
  parameter int FRAC_BITS   = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [grmc_pkg::POS_IN_W-1:0]      in_eye_x,
  input  wire logic [grmc_pkg::POS_IN_W-1:0]      in_eye_y,
  input  wire logic [grmc_pkg::ANGLE_W-1:0]       in_ray_angle,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_hit,
  output logic [grmc_pkg::DIST_W-1:0]             out_distance,
  output logic [grmc_pkg::SHADE_W-1:0]            out_shade,
  output logic [grmc_pkg::ROWS_W-1:0]             out_rows_above,
  output logic [grmc_pkg::ROWS_W-1:0]             out_rows_below,
  input  wire logic                               cfg_we,
  input  wire logic [grmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [grmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int TRIG_W   = FRAC_BITS + 2;
  localparam int MAG_W    = FRAC_BITS + 1;
  localparam int MUL_W    = grmc_pkg::STEP_W + MAG_W;
  localparam int COMP_W   = grmc_pkg::STEP_W + 1;
  localparam int SPAN_W   = $clog2(MAP_SIDE) + FRAC_BITS;
  localparam int POS_W    = ((grmc_pkg::POS_IN_W > SPAN_W) ? grmc_pkg::POS_IN_W : SPAN_W) + 2;
  localparam longint ROWS_NUM_MAX  = 2 * longint'(HALF_ROWS) * 65535 + 262143;
  localparam longint SHADE_NUM_MAX = 14 * 262143 + 131071;
  localparam longint NUM_MAX = (ROWS_NUM_MAX > SHADE_NUM_MAX) ? ROWS_NUM_MAX : SHADE_NUM_MAX;
  localparam int NUM_W    = $clog2(NUM_MAX + 1);
  localparam int DEN_W    = grmc_pkg::DIST_W + 1;

  localparam logic signed [POS_W-1:0] HALF_CELL = POS_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [POS_W-1:0] MAP_LIM   = POS_W'(MAP_SIDE);
  localparam logic [MUL_W-1:0]        MUL_HALF  = MUL_W'(1 << (FRAC_BITS - 1));
  localparam logic [NUM_W-1:0]        ROWS_K    = NUM_W'(2 * HALF_ROWS);
  localparam logic [NUM_W-1:0]        ROWS_LIM  = NUM_W'(HALF_ROWS);
  localparam logic [NUM_W-1:0]        SHADE_LIM = NUM_W'(grmc_pkg::SHADE_FAR);
  localparam logic [grmc_pkg::ROWS_W-1:0] ROWS_FULL = grmc_pkg::ROWS_W'(HALF_ROWS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DX,
    S_DY,
    S_MARCH,
    S_SHD,
    S_SHD_W,
    S_ABV,
    S_ABV_W,
    S_BLW,
    S_BLW_W,
    S_DONE
  } state_t;

  // configuration
  logic [grmc_pkg::CFG_DATA_W-1:0] map_r [grmc_pkg::MAP_REGS];
  logic [grmc_pkg::STEP_W-1:0]     step_r;
  logic [grmc_pkg::VIEW_W-1:0]     view_r;
  logic [grmc_pkg::HEIGHT_W-1:0]   wall_above_r;
  logic [grmc_pkg::HEIGHT_W-1:0]   eye_height_r;
  logic [grmc_pkg::MAP_BITS-1:0]   map_w;

  // sequencer and datapath
  state_t                        state_r, state_nxt;
  logic signed [POS_W-1:0]       px_r, px_nxt;
  logic signed [POS_W-1:0]       py_r, py_nxt;
  logic signed [POS_W-1:0]       dx_r, dx_nxt;
  logic signed [POS_W-1:0]       dy_r, dy_nxt;
  logic [grmc_pkg::DIST_W-1:0]   dist_r, dist_nxt;
  logic                          hit_r, hit_nxt;
  logic [grmc_pkg::SHADE_W-1:0]  shade_r, shade_nxt;
  logic [grmc_pkg::ROWS_W-1:0]   above_r, above_nxt;
  logic [grmc_pkg::ROWS_W-1:0]   below_r, below_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_hit_r, out_hit_nxt;
  logic [grmc_pkg::DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic [grmc_pkg::SHADE_W-1:0]  out_shade_r, out_shade_nxt;
  logic [grmc_pkg::ROWS_W-1:0]   out_above_r, out_above_nxt;
  logic [grmc_pkg::ROWS_W-1:0]   out_below_r, out_below_nxt;

  // shared step multiplier
  logic signed [TRIG_W-1:0]      rom_cos, rom_sin;
  logic signed [TRIG_W-1:0]      mul_c;
  logic                          mul_neg;
  logic [MAG_W-1:0]              mul_mag;
  logic [MUL_W-1:0]              mul_prod;
  logic [MUL_W-1:0]              mul_rnd;
  logic [COMP_W-1:0]             comp_mag;
  logic signed [POS_W-1:0]       comp_ext;
  logic signed [POS_W-1:0]       comp;
  logic [grmc_pkg::STEP_W-1:0]   step_eff;

  // wall test
  logic signed [POS_W-1:0]       sx, sy;
  logic signed [POS_W-1:0]       cell_x, cell_y;
  logic                          on_map;
  logic [2*grmc_pkg::CELL_W-1:0] bit_idx;
  logic                          wall;
  logic                          in_range;

  // divider
  logic                          div_start;
  logic [NUM_W-1:0]              div_num;
  logic [DEN_W-1:0]              div_den;
  grmc_pkg::div_status_t         div_status;
  logic [NUM_W-1:0]              div_quo;
  logic [NUM_W-1:0]              shade_num;
  logic [NUM_W-1:0]              above_num;
  logic [NUM_W-1:0]              below_num;
  logic [grmc_pkg::ROWS_W-1:0]   rows_clamped;
  logic [grmc_pkg::SHADE_W-1:0]  shade_clamped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < grmc_pkg::MAP_REGS; i++) begin
        map_r[i] <= '0;
      end
      step_r       <= grmc_pkg::STEP_RESET;
      view_r       <= grmc_pkg::VIEW_RESET;
      wall_above_r <= grmc_pkg::WALL_ABOVE_RESET;
      eye_height_r <= grmc_pkg::EYE_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (grmc_pkg::cfg_reg_t'(cfg_index))
        grmc_pkg::REG_MAP_0_3:     map_r[0] <= cfg_data;
        grmc_pkg::REG_MAP_4_7:     map_r[1] <= cfg_data;
        grmc_pkg::REG_MAP_8_11:    map_r[2] <= cfg_data;
        grmc_pkg::REG_MAP_12_15:   map_r[3] <= cfg_data;
        grmc_pkg::REG_STEP_LENGTH: step_r <= cfg_data[grmc_pkg::STEP_W-1:0];
        grmc_pkg::REG_VIEW_DIST:   view_r <= cfg_data[grmc_pkg::VIEW_W-1:0];
        grmc_pkg::REG_WALL_ABOVE:  wall_above_r <= cfg_data[grmc_pkg::HEIGHT_W-1:0];
        grmc_pkg::REG_EYE_HEIGHT:  eye_height_r <= cfg_data[grmc_pkg::HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign map_w = {map_r[3], map_r[2], map_r[1], map_r[0]};

  grmc_trig_rom #(
    .ANGLE_STEPS (ANGLE_STEPS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_trig_rom (
    .clk   (clk),
    .rd_en (in_valid && in_ready),
    .addr  (in_ray_angle),
    .cos_q (rom_cos),
    .sin_q (rom_sin)
  );

  grmc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .status (div_status),
    .quo    (div_quo)
  );

  // step component: round(step * |c|) with the sign of c, halves away from zero
  always_comb begin
    step_eff = (step_r == '0) ? grmc_pkg::STEP_W'(1) : step_r;
    mul_c    = (state_r == S_DX) ? rom_cos : rom_sin;
    mul_neg  = mul_c[TRIG_W-1];
    mul_mag  = mul_neg ? MAG_W'(-mul_c) : MAG_W'(mul_c);
    mul_prod = MUL_W'(step_eff) * MUL_W'(mul_mag);
    mul_rnd  = mul_prod + MUL_HALF;
    comp_mag = mul_rnd[FRAC_BITS +: COMP_W];
    comp_ext = {{(POS_W - COMP_W){1'b0}}, comp_mag};
    comp     = mul_neg ? -comp_ext : comp_ext;
  end

  // cell by rounding; anything off the map is wall
  always_comb begin
    sx       = px_r + HALF_CELL;
    sy       = py_r + HALF_CELL;
    cell_x   = sx >>> FRAC_BITS;
    cell_y   = sy >>> FRAC_BITS;
    on_map   = (sx > 0) && (sy > 0) && (cell_x < MAP_LIM) && (cell_y < MAP_LIM);
    bit_idx  = {sy[FRAC_BITS +: grmc_pkg::CELL_W], sx[FRAC_BITS +: grmc_pkg::CELL_W]};
    wall     = !on_map || map_w[bit_idx];
    in_range = (dist_r < {1'b0, view_r});
  end

  always_comb begin
    shade_num = (NUM_W'(dist_r) << 4) - (NUM_W'(dist_r) << 1) + NUM_W'(view_r);
    above_num = ROWS_K * NUM_W'(wall_above_r) + NUM_W'(dist_r);
    below_num = ROWS_K * NUM_W'(eye_height_r) + NUM_W'(dist_r);
    rows_clamped  = (div_quo > ROWS_LIM) ? ROWS_FULL : div_quo[grmc_pkg::ROWS_W-1:0];
    shade_clamped = (div_quo > SHADE_LIM) ? grmc_pkg::SHADE_FAR
                                          : div_quo[grmc_pkg::SHADE_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dist_nxt      = dist_r;
    hit_nxt       = hit_r;
    shade_nxt     = shade_r;
    above_nxt     = above_r;
    below_nxt     = below_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_dist_nxt  = out_dist_r;
    out_shade_nxt = out_shade_r;
    out_above_nxt = out_above_r;
    out_below_nxt = out_below_r;
    div_start     = 1'b0;
    div_num       = shade_num;
    div_den       = {1'b0, view_r, 1'b0};
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          px_nxt    = {{(POS_W - grmc_pkg::POS_IN_W){1'b0}}, in_eye_x};
          py_nxt    = {{(POS_W - grmc_pkg::POS_IN_W){1'b0}}, in_eye_y};
          dist_nxt  = '0;
          state_nxt = S_DX;
        end
      end
      S_DX: begin
        dx_nxt    = comp;
        state_nxt = S_DY;
      end
      S_DY: begin
        dy_nxt    = comp;
        state_nxt = S_MARCH;
      end
      S_MARCH: begin
        if (in_range && !wall) begin
          px_nxt   = px_r + dx_r;
          py_nxt   = py_r + dy_r;
          dist_nxt = dist_r + grmc_pkg::DIST_W'(step_eff);
        end else begin
          // the final position is tested even when the limit stopped the march
          hit_nxt   = wall;
          shade_nxt = grmc_pkg::SHADE_FAR;
          above_nxt = '0;
          below_nxt = '0;
          state_nxt = S_SHD;
        end
      end
      S_SHD: begin
        if (hit_r && in_range) begin
          div_start = 1'b1;
          state_nxt = S_SHD_W;
        end else begin
          state_nxt = S_ABV;
        end
      end
      S_SHD_W: begin
        if (div_status.done) begin
          shade_nxt = shade_clamped;
          state_nxt = S_ABV;
        end
      end
      S_ABV: begin
        div_num = above_num;
        div_den = {dist_r, 1'b0};
        if (!hit_r) begin
          state_nxt = S_DONE;
        end else if (dist_r == '0) begin
          above_nxt = ROWS_FULL;
          below_nxt = ROWS_FULL;
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_ABV_W;
        end
      end
      S_ABV_W: begin
        if (div_status.done) begin
          above_nxt = rows_clamped;
          state_nxt = S_BLW;
        end
      end
      S_BLW: begin
        div_num   = below_num;
        div_den   = {dist_r, 1'b0};
        div_start = 1'b1;
        state_nxt = S_BLW_W;
      end
      S_BLW_W: begin
        if (div_status.done) begin
          below_nxt = rows_clamped;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_dist_nxt  = dist_r;
          out_shade_nxt = shade_r;
          out_above_nxt = above_r;
          out_below_nxt = below_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    dist_r      <= dist_nxt;
    hit_r       <= hit_nxt;
    shade_r     <= shade_nxt;
    above_r     <= above_nxt;
    below_r     <= below_nxt;
    out_hit_r   <= out_hit_nxt;
    out_dist_r  <= out_dist_nxt;
    out_shade_r <= out_shade_nxt;
    out_above_r <= out_above_nxt;
    out_below_r <= out_below_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_distance   = out_dist_r;
  assign out_shade      = out_shade_r;
  assign out_rows_above = out_above_r;
  assign out_rows_below = out_below_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DX)
    else $error("accepted transfer did not start the step setup");

  a_miss_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |->
      out_shade_r == grmc_pkg::SHADE_FAR && out_above_r == '0 && out_below_r == '0)
    else $error("result without hit carries shade or rows");

  a_shade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_shade_r <= grmc_pkg::SHADE_FAR)
    else $error("shade beyond the ramp");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.done |->
      state_r == S_SHD_W || state_r == S_ABV_W || state_r == S_BLW_W)
    else $error("divider finished outside a wait state");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.busy |-> !div_start)
    else $error("division requested while one is running");

endmodule
`default_nettype wire

/* tb/grid_ray_march_column_top_test.sv */
// Self-checking bench for the grid ray marcher: a directed ray table, then random rays over several register settings.
module grid_ray_march_column_top_test;
  import grmc_pkg::*;

  localparam int HALF_ROWS    = 40;
  localparam int MAP_SIDE     = 16;
  localparam int ANGLE_STEPS  = 4096;
  localparam int FRAC         = 12;
  localparam int FAR_SHADE    = 6;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int MAX_PRINTS   = 60;
  localparam int DRAIN_CYCLES = 2000;
  localparam longint unsigned HALF_TURN    = 64'd3373259426;
  localparam longint unsigned QUARTER_TURN = 64'd1686629713;
  localparam longint unsigned FULL_TURN    = 64'd6746518852;

  typedef struct packed {
    logic                hit;
    logic [DIST_W-1:0]   path_len;
    logic [SHADE_W-1:0]  shade;
    logic [ROWS_W-1:0]   above;
    logic [ROWS_W-1:0]   below;
  } column_t;

  typedef struct packed {
    logic [POS_IN_W-1:0] x;
    logic [POS_IN_W-1:0] y;
    logic [ANGLE_W-1:0]  ang;
    logic                typed;
    column_t             want;
  } ray_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [POS_IN_W-1:0]   in_eye_x = '0;
  logic [POS_IN_W-1:0]   in_eye_y = '0;
  logic [ANGLE_W-1:0]    in_ray_angle = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_hit;
  logic [DIST_W-1:0]     out_distance;
  logic [SHADE_W-1:0]    out_shade;
  logic [ROWS_W-1:0]     out_rows_above;
  logic [ROWS_W-1:0]     out_rows_below;
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_index = REG_MAP_0_3;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the register file
  logic [63:0]           map_word [MAP_REGS];
  logic [STEP_W-1:0]     step_cfg;
  logic [VIEW_W-1:0]     view_cfg;
  logic [HEIGHT_W-1:0]   above_cfg;
  logic [HEIGHT_W-1:0]   eye_cfg;

  longint                sin_rom [ANGLE_STEPS];
  longint                cos_rom [ANGLE_STEPS];
  column_t               pending_columns [$];
  ray_row_t              directed_rays [$];
  column_t               want_col;

  int                    errors = 0;
  int                    columns_seen = 0;
  int                    walls_hit = 0;
  int                    rays_sent = 0;
  int                    settings_used = 1;
  int                    cycles = 0;
  bit                    steady = 1'b0;

  grid_ray_march_column_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_eye_x       (in_eye_x),
    .in_eye_y       (in_eye_y),
    .in_ray_angle   (in_ray_angle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_distance   (out_distance),
    .out_shade      (out_shade),
    .out_rows_above (out_rows_above),
    .out_rows_below (out_rows_below),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Sine of a Q30 angle by Taylor series, rounded to Q.12
  function automatic longint taylor_sine(longint unsigned ang);
    longint unsigned th, t, sum_pos, sum_neg, mag;
    bit              neg;
    int              k;
    th  = ang;
    neg = 1'b0;
    if (th > HALF_TURN) begin
      neg = 1'b1;
      th  = FULL_TURN - th;
    end
    if (th > QUARTER_TURN) th = HALF_TURN - th;
    t       = th;
    sum_pos = th;
    sum_neg = 0;
    for (k = 1; k <= 10; k++) begin
      t = (t * th) >> 30;
      t = (t * th) >> 30;
      t = t / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum_neg += t;
      else sum_pos += t;
    end
    mag = (sum_pos > sum_neg) ? sum_pos - sum_neg : 0;
    mag = (mag + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    if (mag > (64'd1 << FRAC)) mag = 64'd1 << FRAC;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // Scale a unit component by the step, halves away from zero
  function automatic longint step_scale(longint stp, longint c);
    longint m, mag;
    m   = (c < 0) ? -c : c;
    mag = (stp * m + (longint'(1) << (FRAC - 1))) >>> FRAC;
    return (c < 0) ? -mag : mag;
  endfunction

  function automatic longint cell_of(longint p);
    if (p >= 0) return (p + (longint'(1) << (FRAC - 1))) >>> FRAC;
    return -((-p + (longint'(1) << (FRAC - 1))) >>> FRAC);
  endfunction

  // Off-map cells are solid
  function automatic bit is_blocked(longint px, longint py);
    longint      cx, cy;
    logic [63:0] w;
    cx = cell_of(px);
    cy = cell_of(py);
    if (cx < 0 || cy < 0 || cx >= MAP_SIDE || cy >= MAP_SIDE) return 1'b1;
    w = map_word[int'(cy / 4)];
    return w[int'(16 * (cy % 4) + cx)];
  endfunction

  function automatic longint rows_for(longint h, longint len);
    longint r;
    if (len == 0) return HALF_ROWS;
    r = (2 * HALF_ROWS * h + len) / (2 * len);
    return (r > HALF_ROWS) ? HALF_ROWS : r;
  endfunction

  function automatic column_t march_column(logic [POS_IN_W-1:0] x, logic [POS_IN_W-1:0] y,
                                           logic [ANGLE_W-1:0] ang);
    column_t res;
    longint  px, py, dx, dy, path, stp, view, sh;
    res  = '0;
    stp  = (step_cfg == 0) ? 1 : step_cfg;
    view = view_cfg;
    dx   = step_scale(stp, cos_rom[ang]);
    dy   = step_scale(stp, sin_rom[ang]);
    px   = x;
    py   = y;
    path = 0;
    while (path < view && !is_blocked(px, py)) begin
      px   += dx;
      py   += dy;
      path += stp;
    end
    res.hit      = is_blocked(px, py);
    res.path_len = path[DIST_W-1:0];
    res.shade    = SHADE_W'(FAR_SHADE);
    if (res.hit) begin
      if (path < view) begin
        sh = (14 * path + view) / (2 * view);
        if (sh > FAR_SHADE) sh = FAR_SHADE;
        res.shade = sh[SHADE_W-1:0];
      end
      res.above = ROWS_W'(rows_for(above_cfg, path));
      res.below = ROWS_W'(rows_for(eye_cfg, path));
    end
    return res;
  endfunction

  function automatic ray_row_t ray(int x, int y, int ang);
    ray_row_t r;
    r     = '0;
    r.x   = x[POS_IN_W-1:0];
    r.y   = y[POS_IN_W-1:0];
    r.ang = ang[ANGLE_W-1:0];
    return r;
  endfunction

  function automatic ray_row_t ray_with(int x, int y, int ang, int hit, int path_len,
                                        int shade, int above, int below);
    ray_row_t r;
    r                = ray(x, y, ang);
    r.typed          = 1'b1;
    r.want.hit       = hit[0];
    r.want.path_len  = path_len[DIST_W-1:0];
    r.want.shade     = shade[SHADE_W-1:0];
    r.want.above     = above[ROWS_W-1:0];
    r.want.below     = below[ROWS_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  // Bias eye positions towards the map borders
  function automatic int pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 65535);
    if (r < 8) return $urandom_range(0, 6143);
    return $urandom_range(59392, 65535);
  endfunction

  function automatic ray_row_t random_ray();
    int t;
    if ($urandom_range(0, 9) < 7) begin
      t = $urandom_range(0, ANGLE_STEPS - 1);
    end else begin
      // near an axis
      t = 1024 * $urandom_range(0, 3) + $urandom_range(0, 8) - 4;
    end
    return ray(pick_pos(), pick_pos(), t);
  endfunction

  function automatic logic [63:0] map_rand(int pct);
    logic [63:0] w;
    int          b;
    for (b = 0; b < 64; b++) w[b] = ($urandom_range(0, 99) < pct);
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH at result %0d: %s", columns_seen, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_MAP_0_3:     map_word[0] = val;
      REG_MAP_4_7:     map_word[1] = val;
      REG_MAP_8_11:    map_word[2] = val;
      REG_MAP_12_15:   map_word[3] = val;
      REG_STEP_LENGTH: step_cfg = val[STEP_W-1:0];
      REG_VIEW_DIST:   view_cfg = val[VIEW_W-1:0];
      REG_WALL_ABOVE:  above_cfg = val[HEIGHT_W-1:0];
      REG_EYE_HEIGHT:  eye_cfg = val[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Hold valid and payload until the transfer; valid stays up when no gap follows
  task automatic drive_ray(ray_row_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_eye_x     <= r.x;
    in_eye_y     <= r.y;
    in_ray_angle <= r.ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_columns.push_back(r.typed ? r.want : march_column(r.x, r.y, r.ang));
    rays_sent++;
  endtask

  task automatic settle();
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_setting(int density, int stp, int view, int above, int eye, int n,
                             bit calm);
    settle();
    set_reg(REG_MAP_0_3, map_rand(density));
    set_reg(REG_MAP_4_7, map_rand(density));
    set_reg(REG_MAP_8_11, map_rand(density));
    set_reg(REG_MAP_12_15, map_rand(density));
    set_reg(REG_STEP_LENGTH, stp);
    set_reg(REG_VIEW_DIST, view);
    set_reg(REG_WALL_ABOVE, above);
    set_reg(REG_EYE_HEIGHT, eye);
    settings_used++;
    steady = calm;
    repeat (n) drive_ray(random_ray());
    in_valid <= 1'b0;
    steady = 1'b0;
  endtask

  initial begin
    int              a;
    longint unsigned th;
    for (a = 0; a < ANGLE_STEPS; a++) begin
      th         = a * FULL_TURN / ANGLE_STEPS;
      sin_rom[a] = taylor_sine(th);
      cos_rom[a] = taylor_sine((th + QUARTER_TURN) % FULL_TURN);
    end
    for (a = 0; a < MAP_REGS; a++) map_word[a] = '0;
    step_cfg  = 12'd41;
    view_cfg  = 17'd65536;
    above_cfg = 16'd4915;
    eye_cfg   = 16'd7373;

    // Eye on or past the map edge is a wall at zero distance; the diagonal sees nothing
    directed_rays.push_back(ray_with(65535, 65535, 0, 1, 0, 0, HALF_ROWS, HALF_ROWS));
    directed_rays.push_back(ray_with(63488, 32768, 2048, 1, 0, 0, HALF_ROWS, HALF_ROWS));
    directed_rays.push_back(ray_with(0, 65535, 3072, 1, 0, 0, HALF_ROWS, HALF_ROWS));
    directed_rays.push_back(ray_with(0, 0, 512, 0, 65559, FAR_SHADE, 0, 0));
    directed_rays.push_back(ray(0, 0, 0));
    directed_rays.push_back(ray(0, 0, 1024));
    directed_rays.push_back(ray(0, 0, 2048));
    directed_rays.push_back(ray(0, 0, 3072));
    directed_rays.push_back(ray(0, 0, 4095));
    directed_rays.push_back(ray(32768, 0, 3072));
    directed_rays.push_back(ray(2047, 2047, 1536));
    directed_rays.push_back(ray(63487, 32768, 0));
    directed_rays.push_back(ray(61439, 61439, 256));
    directed_rays.push_back(ray(32768, 32768, 1));
    directed_rays.push_back(ray(32768, 32768, 2047));
    directed_rays.push_back(ray(32768, 32768, 2049));
    directed_rays.push_back(ray(21845, 43690, 2730));
    directed_rays.push_back(ray(43690, 21845, 1365));
    directed_rays.push_back(ray(40000, 12345, 3000));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rays[i]) drive_ray(directed_rays[i]);
    in_valid <= 1'b0;

    run_setting(25, 41, 65536, $urandom_range(0, 65535), $urandom_range(0, 65535), 60, 1'b0);
    run_setting(10, 4095, 131071, 65535, 0, 60, 1'b0);
    run_setting(40, 1, 4096, 0, 65535, 30, 1'b0);
    run_setting(20, $urandom_range(100, 4095), $urandom_range(4096, 131071),
                $urandom_range(0, 65535), $urandom_range(0, 65535), 60, 1'b1);
    run_setting(0, $urandom_range(300, 2000), 131071, 4915, 7373, 50, 1'b0);
    run_setting(100, 2048, 4096, $urandom_range(0, 65535), $urandom_range(0, 65535), 20, 1'b0);
    run_setting(30, 41, 65536, $urandom_range(0, 65535), $urandom_range(0, 65535), 50, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("cast %0d rays (%0d from the directed table) over %0d register settings",
             rays_sent, directed_rays.size(), settings_used);
    $display("checked %0d columns: %0d ended on a wall, %0d open", columns_seen, walls_hit,
             columns_seen - walls_hit);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side back-pressure
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      columns_seen++;
      if (pending_columns.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding");
      end else begin
        want_col = pending_columns.pop_front();
        compare_field("hit", out_hit, want_col.hit);
        compare_field("distance", out_distance, want_col.path_len);
        compare_field("shade", out_shade, want_col.shade);
        compare_field("rows_above", out_rows_above, want_col.above);
        compare_field("rows_below", out_rows_below, want_col.below);
        if (out_hit === 1'b1) walls_hit++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("watchdog: run still going after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
